### hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

	localparam int WORD_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;
	localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty_flag;
	} res_t;

endpackage

### hdl/double_ended_queue.sv
// Double-ended queue on a circular buffer: top level and operation sequencer.
// After an op transfer it steps through S_READ and S_DONE for the two memory reads;
// res_valid rises as S_DONE is left with res free. No new op is taken before S_IDLE.
// The next op is taken while a finished result waits on a stalled res port.
// Reset (arst_n low) clears head, tail, count and handshake state at once;
//   the element store is left undefined and needs no clearing pass.
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an op
	localparam logic [1:0] S_READ = 2'd1;  // popped word arrives, front/back read issued
	localparam logic [1:0] S_DONE = 2'd2;  // front/back arrive, result built

	logic [1:0]    state_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;

	// per-op info held from the transfer to the result
	logic [STAT_W-1:0]        status_q;
	logic                     pop_ok_q;
	logic signed [WORD_W-1:0] popped_q;
	logic                     res_valid_q;
	res_t                     res_q;

	// next pointer state and memory controls
	logic [AW-1:0]         head_n, tail_n;
	logic [CW-1:0]         cnt_n;
	logic [STAT_W-1:0]     status_n;
	logic                  pop_ok_n;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         pop_addr;
	logic                  rd_en_a, rd_en_b;
	logic [AW-1:0]         rd_addr_a, rd_addr_b;
	logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;
	logic [DATA_WIDTH-1:0] wr_data;

	logic op_xfer;
	logic full, empty;
	logic res_free;

	function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
		return (i == IDX_LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_down(input logic [AW-1:0] i);
		return (i == '0) ? IDX_LAST : i - AW'(1);
	endfunction

	// stored word read back sign-extended from DATA_WIDTH, fit to the field
	function automatic logic signed [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] w);
		return WORD_W'($signed(w));
	endfunction

	assign op_stall = (state_q != S_IDLE);
	assign op_xfer  = op_valid && !op_stall;
	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign wr_data  = DATA_WIDTH'($unsigned(op.value));

	// operation decode: pointer update, write, and address of the popped word
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		status_n = ST_OK;
		pop_ok_n = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		pop_addr = head_q;
		case (op.func)
			FN_PUSH_BACK: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = op_xfer;
					wr_addr = tail_q;
					tail_n  = idx_up(tail_q);
					cnt_n   = cnt_q + CW'(1);
				end
			end
			FN_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = op_xfer;
					wr_addr = idx_down(head_q);
					head_n  = idx_down(head_q);
					cnt_n   = cnt_q + CW'(1);
				end
			end
			FN_POP_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					pop_ok_n = 1'b1;
					pop_addr = idx_down(tail_q);
					tail_n   = idx_down(tail_q);
					cnt_n    = cnt_q - CW'(1);
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					pop_ok_n = 1'b1;
					pop_addr = head_q;
					head_n   = idx_up(head_q);
					cnt_n    = cnt_q - CW'(1);
				end
			end
			FN_CLEAR: begin
				head_n = '0;
				tail_n = '0;
				cnt_n  = '0;
			end
			default: begin
				// query and unused codes leave the state alone
			end
		endcase
	end

	// Port A: popped word at transfer, then the new front. Port B: the new back.
	// The front/back read is issued in S_READ, after any push write has landed, so it sees new data.
	always_comb begin
		rd_en_a   = op_xfer;
		rd_addr_a = pop_addr;
		rd_en_b   = 1'b0;
		rd_addr_b = idx_down(tail_q);
		if (state_q == S_READ) begin
			rd_en_a   = 1'b1;
			rd_addr_a = head_q;
			rd_en_b   = 1'b1;
		end
	end

	dq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en_a   (rd_en_a),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_en_b   (rd_en_b),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	// result register is free when empty or being taken this cycle
	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op_xfer) begin
						head_q  <= head_n;
						tail_q  <= tail_n;
						cnt_q   <= cnt_n;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// wait here until the previous result has gone out
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (op_xfer) begin
			status_q <= status_n;
			pop_ok_q <= pop_ok_n;
		end
		if (state_q == S_READ) begin
			popped_q <= pop_ok_q ? to_word(rd_data_a) : WORD_NONE;
		end
		if (state_q == S_DONE && res_free) begin
			res_q.popped_value  <= popped_q;
			res_q.status        <= status_q;
			res_q.front_value   <= empty ? WORD_NONE : to_word(rd_data_a);
			res_q.back_value    <= empty ? WORD_NONE : to_word(rd_data_b);
			res_q.count         <= COUNT_W'(cnt_q);
			res_q.is_empty_flag <= empty;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### hdl/dq_ram.sv
// Element store: one write port, two registered read ports.
module dq_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  rd_en_a,
	input  logic [AW-1:0]         rd_addr_a,
	output logic [DATA_WIDTH-1:0] rd_data_a,
	input  logic                  rd_en_b,
	input  logic [AW-1:0]         rd_addr_b,
	output logic [DATA_WIDTH-1:0] rd_data_b
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while the port is idle
	always_ff @(posedge clk) begin
		if (rd_en_a) begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

### hdl/dq_checker.sv
// Port-level checks on the queue result channel, bound to the top level.
module dq_checker import dq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("res changed while stalled");

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.is_empty_flag == (res.count == '0)))
		else $error("empty flag does not match count");

	// an empty queue reports no front or back element
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_empty_flag |->
			(res.front_value == WORD_NONE) && (res.back_value == WORD_NONE))
		else $error("empty queue shows a front or back element");

	// a failed pop leaves an empty queue and yields no word
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_EMPTY) |->
			res.is_empty_flag && (res.popped_value == WORD_NONE))
		else $error("failed pop with elements or a word");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
